>>> sv/write_buffer_pool_table_assert.svh
// Assertion macros for the write buffer pool table.
// WBPT_ASSERT runs under reset masking, WBPT_ASSERT_ALWAYS checks during reset too.
`ifndef WRITE_BUFFER_POOL_TABLE_ASSERT_SVH
`define WRITE_BUFFER_POOL_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WBPT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("write buffer pool table assertion failed");
`define WBPT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("write buffer pool table assertion failed");
`else
`define WBPT_ASSERT(label, prop)
`define WBPT_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> sv/wbpt_pkg.sv
package wbpt_pkg;

   localparam int POOL_DEPTH         = 4;
   localparam int ENTRIES_PER_BUFFER = 64;
   localparam int TOTAL_SLOTS        = POOL_DEPTH * ENTRIES_PER_BUFFER;

   localparam int BUF_W  = $clog2(POOL_DEPTH);
   localparam int SLOT_W = $clog2(ENTRIES_PER_BUFFER);
   localparam int CNT_W  = $clog2(ENTRIES_PER_BUFFER + 1);
   localparam int IDX_W  = $clog2(TOTAL_SLOTS);

   localparam int KIND_W    = 2;
   localparam int LBA_W     = 32;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 3;
   localparam int SIDX_W    = 2;
   localparam int SCNT_W    = 7;

   localparam logic [KIND_W-1:0] KIND_HOST  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GC    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ALIAS = 2'd3;  // decoded as a query

   localparam logic [STATUS_W-1:0] STATUS_ADDED       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERWRITTEN = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_SKIPPED     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_HIT         = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_MISS        = 3'd4;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_FINISH
   } state_type;

   typedef struct packed {
      logic [LBA_W-1:0]     address;
      logic [PAYLOAD_W-1:0] data;
   } entry_type;

   function automatic logic [IDX_W-1:0] slot_index(logic [BUF_W-1:0] b,
                                                   logic [SLOT_W-1:0] s);
      return IDX_W'(b) * IDX_W'(ENTRIES_PER_BUFFER) + IDX_W'(s);
   endfunction

endpackage

>>> sv/wbpt_req_if.sv
interface wbpt_req_if;
   import wbpt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [LBA_W-1:0]     lba;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, kind, lba, payload, input ready);
   modport sink (input valid, kind, lba, payload, output ready);
endinterface

>>> sv/wbpt_rsp_if.sv
interface wbpt_rsp_if;
   import wbpt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [PAYLOAD_W-1:0] read_payload;
   logic                 sealed;
   logic [SIDX_W-1:0]    sealed_index;
   logic [SCNT_W-1:0]    sealed_count;

   modport source (output valid, status, read_payload, sealed, sealed_index, sealed_count,
                   input ready);
   modport sink (input valid, status, read_payload, sealed, sealed_index, sealed_count,
                 output ready);
endinterface

>>> sv/write_buffer_pool_table.sv
// Channel   Dir  Fields                                                     Transfer
// req_bus   in   kind, lba, payload                                         valid & ready
// rsp_bus   out  status, read_payload, sealed, sealed_index, sealed_count   valid & ready
//
// One item at a time. A host write scans the filled slots of the current buffer; a gc
// write or query scans filled slots of all buffers, newest first, until a hit.
// A scan reads at most 255 slots with the defaults, since the current buffer holds at most
// 63 entries; slots are read through the single read port of the entry memory (one slot
// per cycle, except when the scan moves on to the previous buffer).
// Reset clears fill counts and the current buffer pointer; no memory clearing pass.
// A finished result waits in the output register; a new request is taken meanwhile.
`include "write_buffer_pool_table_assert.svh"

module write_buffer_pool_table (
   input logic    clock,
   input logic    reset,
   wbpt_req_if.sink   req_bus,
   wbpt_rsp_if.source rsp_bus
);
   import wbpt_pkg::*;

   entry_type entry_mem [TOTAL_SLOTS];
   entry_type rd_entry_ff;

   state_type state_ff, state_in;
   logic [BUF_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] fill_ff [POOL_DEPTH];
   logic [CNT_W-1:0] fill_in [POOL_DEPTH];

   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [LBA_W-1:0]     lba_ff, lba_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;

   logic [BUF_W-1:0] scan_buf_ff, scan_buf_in;
   logic [CNT_W-1:0] scan_slot_ff, scan_slot_in;
   logic [BUF_W-1:0] bufs_left_ff, bufs_left_in;
   logic             issue_on_ff, issue_on_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0] cmp_index_ff, cmp_index_in;

   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_index_ff, hit_index_in;
   logic [PAYLOAD_W-1:0] hit_data_ff, hit_data_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic                 rsp_sealed_ff, rsp_sealed_in;
   logic [SIDX_W-1:0]    rsp_sidx_ff, rsp_sidx_in;
   logic [SCNT_W-1:0]    rsp_scnt_ff, rsp_scnt_in;

   logic             mem_re, mem_we;
   logic [IDX_W-1:0] mem_raddr, mem_waddr;
   entry_type        mem_wdata;

   logic req_fire, finish_go, seal_now, is_query, is_gc;
   logic [BUF_W-1:0] next_buf, prev_buf;

   assign req_bus.ready = (state_ff == STATE_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.read_payload = rsp_payload_ff;
   assign rsp_bus.sealed       = rsp_sealed_ff;
   assign rsp_bus.sealed_index = rsp_sidx_ff;
   assign rsp_bus.sealed_count = rsp_scnt_ff;

   assign is_query  = (kind_ff == KIND_QUERY) || (kind_ff == KIND_ALIAS);
   assign is_gc     = (kind_ff == KIND_GC);
   assign finish_go = (state_ff == STATE_FINISH) && (!rsp_valid_ff || rsp_bus.ready);
   assign seal_now  = finish_go && !is_query && !hit_ff
                      && (fill_ff[cur_ff] == CNT_W'(ENTRIES_PER_BUFFER - 1));
   assign next_buf  = (cur_ff == BUF_W'(POOL_DEPTH - 1)) ? '0 : cur_ff + 1'b1;
   assign prev_buf  = (scan_buf_ff == '0) ? BUF_W'(POOL_DEPTH - 1) : scan_buf_ff - 1'b1;
   assign mem_raddr = slot_index(scan_buf_ff, scan_slot_ff[SLOT_W-1:0]);

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      fill_in        = fill_ff;
      kind_in        = kind_ff;
      lba_in         = lba_ff;
      payload_in     = payload_ff;
      scan_buf_in    = scan_buf_ff;
      scan_slot_in   = scan_slot_ff;
      bufs_left_in   = bufs_left_ff;
      issue_on_in    = issue_on_ff;
      cmp_valid_in   = 1'b0;
      cmp_index_in   = cmp_index_ff;
      hit_in         = hit_ff;
      hit_index_in   = hit_index_ff;
      hit_data_in    = hit_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_sealed_in  = rsp_sealed_ff;
      rsp_sidx_in    = rsp_sidx_ff;
      rsp_scnt_in    = rsp_scnt_ff;
      mem_re         = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = hit_index_ff;
      mem_wdata      = '{address: lba_ff, data: payload_ff};

      case (state_ff)
         STATE_IDLE: begin
            if (req_fire) begin
               kind_in      = req_bus.kind;
               lba_in       = req_bus.lba;
               payload_in   = req_bus.payload;
               scan_buf_in  = cur_ff;
               scan_slot_in = '0;
               // host writes look only in the current buffer
               bufs_left_in = (req_bus.kind == KIND_HOST) ? '0 : BUF_W'(POOL_DEPTH - 1);
               issue_on_in  = 1'b1;
               hit_in       = 1'b0;
               state_in     = STATE_SCAN;
            end
         end
         STATE_SCAN: begin
            if (cmp_valid_ff && rd_entry_ff.address == lba_ff) begin
               hit_in       = 1'b1;
               hit_index_in = cmp_index_ff;
               hit_data_in  = rd_entry_ff.data;
               state_in     = STATE_FINISH;
            end else if (issue_on_ff) begin
               if (scan_slot_ff < fill_ff[scan_buf_ff]) begin
                  mem_re       = 1'b1;
                  cmp_valid_in = 1'b1;
                  cmp_index_in = mem_raddr;
                  scan_slot_in = scan_slot_ff + 1'b1;
               end else if (bufs_left_ff != '0) begin
                  scan_buf_in  = prev_buf;
                  scan_slot_in = '0;
                  bufs_left_in = bufs_left_ff - 1'b1;
               end else begin
                  issue_on_in = 1'b0;
               end
            end else begin
               state_in = STATE_FINISH;
            end
         end
         STATE_FINISH: begin
            if (finish_go) begin
               state_in       = STATE_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '0;
               rsp_sealed_in  = 1'b0;
               rsp_sidx_in    = '0;
               rsp_scnt_in    = '0;
               if (is_query) begin
                  rsp_status_in  = hit_ff ? STATUS_HIT : STATUS_MISS;
                  rsp_payload_in = hit_ff ? hit_data_ff : '0;
               end else if (is_gc && hit_ff) begin
                  rsp_status_in = STATUS_SKIPPED;
               end else if (hit_ff) begin
                  mem_we        = 1'b1;
                  rsp_status_in = STATUS_OVERWRITTEN;
               end else begin
                  mem_we          = 1'b1;
                  mem_waddr       = slot_index(cur_ff, fill_ff[cur_ff][SLOT_W-1:0]);
                  fill_in[cur_ff] = fill_ff[cur_ff] + 1'b1;
                  rsp_status_in   = STATUS_ADDED;
                  if (seal_now) begin
                     rsp_sealed_in     = 1'b1;
                     rsp_sidx_in       = SIDX_W'(cur_ff);
                     rsp_scnt_in       = SCNT_W'(ENTRIES_PER_BUFFER);
                     cur_in            = next_buf;
                     fill_in[next_buf] = '0;
                  end
               end
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         cur_ff       <= '0;
         issue_on_ff  <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < POOL_DEPTH; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         issue_on_ff  <= issue_on_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      lba_ff         <= lba_in;
      payload_ff     <= payload_in;
      scan_buf_ff    <= scan_buf_in;
      scan_slot_ff   <= scan_slot_in;
      bufs_left_ff   <= bufs_left_in;
      cmp_index_ff   <= cmp_index_in;
      hit_ff         <= hit_in;
      hit_index_ff   <= hit_index_in;
      hit_data_ff    <= hit_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_sealed_ff  <= rsp_sealed_in;
      rsp_sidx_ff    <= rsp_sidx_in;
      rsp_scnt_ff    <= rsp_scnt_in;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_entry_ff <= entry_mem[mem_raddr];
      end
   end

   `WBPT_ASSERT(a_cur_never_full,
      (state_ff == STATE_IDLE) |-> (fill_ff[cur_ff] < CNT_W'(ENTRIES_PER_BUFFER)))
   `WBPT_ASSERT(a_seal_rotates,
      seal_now |=> (fill_ff[cur_ff] == '0) && (cur_ff != $past(cur_ff)))
   `WBPT_ASSERT(a_scan_starts_current,
      req_fire |=> (state_ff == STATE_SCAN) && (scan_buf_ff == cur_ff))
   `WBPT_ASSERT(a_result_held,
      (state_ff == STATE_FINISH && rsp_valid_ff && !rsp_bus.ready)
         |=> (rsp_bus.valid && state_ff == STATE_FINISH))
   `WBPT_ASSERT_ALWAYS(a_idle_after_reset,
      reset |=> (rsp_bus.valid == 1'b0) && (state_ff == STATE_IDLE))

endmodule
